@@ hdl/hbit_pkg.sv @@
// hbit_pkg: types, sizes and codes shared by the hashed block index table.
// No dependencies; imported by hbit_bucket_op and hashed_block_index_table.
`default_nettype none

package hbit_pkg;

  // Table geometry. BUCKETS must be a power of two (bucket = low key bits).
  localparam int BUCKETS  = 64;
  localparam int WAYS     = 4;
  localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

  localparam int KIND_W   = 2;
  localparam int KEY_W    = 32;
  localparam int SLOT_W   = 16;
  localparam int STATUS_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DELETE = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic              valid;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot;
  } entry_t;

  // One bucket: index 0 is the newest entry.
  typedef entry_t [WAYS-1:0] row_t;

  // Outcome of one operation on a bucket.
  typedef struct packed {
    logic                wr_en;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   found;
  } op_res_t;

endpackage

`default_nettype wire

@@ hdl/hashed_block_index_table.sv @@
// hashed_block_index_table: top level, bucket memory and command sequencing.
// Depends on hbit_pkg and hbit_bucket_op.
`default_nettype none

// Block-number to cache-slot index, kept as a bucketed hash table.
//
// Command channel: a transfer happens at a rising edge where start_i is high
// and busy_o is low; kind_i, block_number_i and slot_index_i are sampled then.
// kind_i: lookup, insert (new entry at bucket head) or delete (newest match).
// Bucket = low bits of block_number_i; each bucket holds WAYS entries as one
// memory row, newest first.
//
// Timing: the accept edge launches the synchronous row read. In the next
// cycle busy_o is high, the row is compared and modified and written back at
// the end of that cycle. The result (status_o, found_index_o) is registered
// after the modify cycle and shown with result_valid_o for exactly one cycle.
// busy_o is low again in that cycle; due to the read-modify-write of the
// single memory port, no command is taken during a modify cycle. Since the
// write lands before the next read is launched, no forwarding is needed.
//
// The receiver cannot stall: each result is a single-cycle transfer.
// Reset: all buckets read as empty. A per-row flag (flops) marks rows that
// were written since reset; an unmarked row reads as all invalid, so there
// is no clearing pass and the block is ready right after reset.
module hashed_block_index_table
  import hbit_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [KEY_W-1:0]    block_number_i,
  input  logic [SLOT_W-1:0]   slot_index_i,
  output logic                result_valid_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [SLOT_W-1:0]   found_index_o
);

  logic                accept;
  logic [BUCKET_W-1:0] bucket;

  // Command held during the modify cycle.
  logic                pend_q;
  logic [KIND_W-1:0]   kind_q;
  logic [KEY_W-1:0]    key_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [BUCKET_W-1:0] addr_q;

  // Bucket memory and its registered read port.
  row_t                mem_q [BUCKETS];
  row_t                rd_row_q;
  logic                rd_init_q;
  logic [BUCKETS-1:0]  row_init_q;

  row_t                cur_row;
  row_t                new_row;
  op_res_t             res;

  // Result register.
  logic                out_vld_q;
  logic [STATUS_W-1:0] status_q;
  logic [SLOT_W-1:0]   found_q;

  assign busy_o = pend_q;
  assign accept = start_i && !pend_q;
  // Power-of-two bucket count: modulo is a slice of the key.
  assign bucket = block_number_i[BUCKET_W-1:0];

  // Rows never written since reset read as empty.
  assign cur_row = rd_init_q ? rd_row_q : '0;

  hbit_bucket_op u_op (
    .row_i  (cur_row),
    .kind_i (kind_q),
    .key_i  (key_q),
    .slot_i (slot_q),
    .row_o  (new_row),
    .res_o  (res)
  );

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q     <= 1'b0;
      out_vld_q  <= 1'b0;
      row_init_q <= '0;
      rd_init_q  <= 1'b0;
    end else begin
      pend_q    <= accept;
      out_vld_q <= pend_q;
      if (accept) begin
        rd_init_q <= row_init_q[bucket];
      end
      if (pend_q && res.wr_en) begin
        row_init_q[addr_q] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_i;
      key_q  <= block_number_i;
      slot_q <= slot_index_i;
      addr_q <= bucket;
    end
    if (pend_q) begin
      status_q <= res.status;
      found_q  <= res.found;
    end
  end

  // Single-port style memory: read on accept, write back in modify cycle.
  always_ff @(posedge clk_i) begin
    if (pend_q && res.wr_en) begin
      mem_q[addr_q] <= new_row;
    end
    if (accept) begin
      rd_row_q <= mem_q[bucket];
    end
  end

  assign result_valid_o = out_vld_q;
  assign status_o       = status_q;
  assign found_index_o  = found_q;

  // Every transfer in yields a result, through pend_q and then out_vld_q.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 result_valid_o)
    else $error("command without result");

  // No result without a command in the modify stage in the cycle before.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(pend_q))
    else $error("result without command");

  // Read and write-back never overlap with a new read.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |=> !pend_q)
    else $error("back-to-back modify cycles");

  // Only a hit may return a nonzero slot.
  a_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o != STATUS_DONE)) |-> (found_index_o == '0))
    else $error("slot reported on miss");

  // Status is always a defined code.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ((status_o == STATUS_DONE) || (status_o == STATUS_MISS) ||
                        (status_o == STATUS_FULL)))
    else $error("bad status code");

endmodule

`default_nettype wire

@@ hdl/hbit_bucket_op.sv @@
// hbit_bucket_op: lookup / insert / delete on one bucket row (combinational).
// Depends on hbit_pkg.
`default_nettype none

module hbit_bucket_op
  import hbit_pkg::*;
(
  input  row_t              row_i,
  input  logic [KIND_W-1:0] kind_i,
  input  logic [KEY_W-1:0]  key_i,
  input  logic [SLOT_W-1:0] slot_i,
  output row_t              row_o,
  output op_res_t           res_o
);

  logic             hit;
  logic [WAY_W-1:0] hit_way;
  row_t             ins_row;
  row_t             del_row;
  entry_t           new_ent;

  // Newest match wins: scan from oldest down so the lowest index sticks.
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (row_i[w].valid && (row_i[w].key == key_i)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  // Insert: new entry at head, older ones move back one way.
  always_comb begin
    new_ent.valid = 1'b1;
    new_ent.key   = key_i;
    new_ent.slot  = slot_i;
    ins_row[0]    = new_ent;
    for (int w = 1; w < WAYS; w++) begin
      ins_row[w] = row_i[w-1];
    end
  end

  // Delete: ways behind the hit move forward, last way cleared.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) < hit_way) begin
        del_row[w] = row_i[w];
      end else if (w < WAYS - 1) begin
        del_row[w] = row_i[(w + 1) % WAYS];
      end else begin
        del_row[w] = '0;
      end
    end
  end

  always_comb begin
    row_o        = row_i;
    res_o.wr_en  = 1'b0;
    res_o.status = STATUS_MISS;
    res_o.found  = '0;
    case (kind_i)
      KIND_LOOKUP: begin
        if (hit) begin
          res_o.status = STATUS_DONE;
          res_o.found  = row_i[hit_way].slot;
        end
      end
      KIND_INSERT: begin
        if (row_i[WAYS-1].valid) begin
          res_o.status = STATUS_FULL;
        end else begin
          row_o        = ins_row;
          res_o.wr_en  = 1'b1;
          res_o.status = STATUS_DONE;
        end
      end
      KIND_DELETE: begin
        if (hit) begin
          row_o        = del_row;
          res_o.wr_en  = 1'b1;
          res_o.status = STATUS_DONE;
        end
      end
      default: begin
        res_o.status = STATUS_MISS;
      end
    endcase
  end

endmodule

`default_nettype wire
